@@ rtl/wbps_pkg.sv @@
// Package with opcodes, field widths and types shared by the pattern search block.
package wbps_pkg;

    localparam int unsigned OpcodeWidth   = 2;
    localparam int unsigned ByteWidth     = 8;
    localparam int unsigned OffsetWidth   = 12;
    localparam int unsigned TextPosWidth  = 15;
    localparam int unsigned HlLenWidth    = 5;
    localparam int unsigned LineChars     = 77;
    localparam int unsigned TextColStart  = 60;
    localparam int unsigned LineBytes     = 16;

    typedef enum logic [OpcodeWidth-1:0] {
        OP_APPEND_DATA    = 2'd0,
        OP_APPEND_PATTERN = 2'd1,
        OP_SEARCH         = 2'd2,
        OP_CLEAR          = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_FETCH,
        ST_CHECK,
        ST_RESULT
    } t_state;

    // Command from the sequencer to the comparator cell row.
    typedef struct packed {
        logic shift;
    } t_cell_ctrl;

endpackage

@@ rtl/wbps_if.sv @@
// Valid/ready stream interface carrying the input item or the result item.
interface wbps_in_if;
    import wbps_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [OpcodeWidth-1:0] opcode;
    logic [ByteWidth-1:0]   byte_value;
    logic [OffsetWidth-1:0] start_offset;
    modport source (output valid, opcode, byte_value, start_offset, input ready);
    modport sink   (input valid, opcode, byte_value, start_offset, output ready);
endinterface

interface wbps_out_if;
    import wbps_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic [OffsetWidth-1:0]  match_offset;
    logic [TextPosWidth-1:0] text_position;
    logic [HlLenWidth-1:0]   highlight_length;
    modport source (output valid, found, match_offset, text_position, highlight_length,
                    input ready);
    modport sink   (input valid, found, match_offset, text_position, highlight_length,
                    output ready);
endinterface

@@ rtl/wbps_cell.sv @@
// One comparator cell: holds a data byte, compares it with a pattern byte and passes data along.
module wbps_cell
    import wbps_pkg::*;
(
    input  logic                 i_clk,
    input  t_cell_ctrl           i_ctrl,
    input  logic [ByteWidth-1:0] i_pat,
    input  logic [ByteWidth-1:0] i_data,
    output logic [ByteWidth-1:0] o_data,
    output logic                 o_eq
);
    logic [ByteWidth-1:0] r_data;
    logic [ByteWidth-1:0] n_data;

    // Data byte shifts toward the lower neighbor on each shift command.
    always_comb begin
        n_data = r_data;
        if (i_ctrl.shift) begin
            n_data = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_eq   = (r_data == i_pat);
endmodule

@@ rtl/wrapping_byte_pattern_search.sv @@
// Top level of the wrapping byte pattern search block.
// Usage: items arrive on the input channel (opcode, byte_value, start_offset)
// with a valid/ready transfer. Appends and clears give no result. A search
// gives one result item on the output channel.
// The pattern sits in a row of PATTERN_DEPTH comparator cells; the data bytes
// are read from a single-port data memory one per cycle and shifted through
// the row, so the window at a position is complete after pattern_count reads.
// During a search each further window goes through check, read and shift,
// and a wrap back to 0 refills the row; the worst case is set by the one
// data memory read port.
// Input ready is low while a search runs; the next item is taken in the
// cycle the result appears. If the receiver stalls, the result holds in the
// output register; appends and clears still flow, and a later search waits
// in its last step until the register is free. Reset clears both counts and
// the controller; no memory clearing pass is needed.
module wrapping_byte_pattern_search
    import wbps_pkg::*;
#(
    parameter int unsigned DATA_DEPTH    = 4096,
    parameter int unsigned PATTERN_DEPTH = 64
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    wbps_in_if.sink   i_in,
    wbps_out_if.source o_out
);
    localparam int unsigned DAW = $clog2(DATA_DEPTH);
    localparam int unsigned DCW = $clog2(DATA_DEPTH + 1);
    localparam int unsigned PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int unsigned PCW = $clog2(PATTERN_DEPTH + 1);
    localparam int unsigned SW  = (DCW > OffsetWidth) ? DCW : OffsetWidth;
    localparam int unsigned CW  = (DCW > PCW) ? DCW : PCW;
    localparam int unsigned LW  = PCW + HlLenWidth;

    // Stores and counts.
    logic [ByteWidth-1:0] r_dmem [DATA_DEPTH];
    logic [ByteWidth-1:0] r_pat  [PATTERN_DEPTH];
    logic [DCW-1:0]       r_dcnt, n_dcnt;
    logic [PCW-1:0]       r_pcnt, n_pcnt;

    t_state r_state, n_state;
    logic [DCW-1:0] r_pos, n_pos;     // window start position
    logic [DCW-1:0] r_rd, n_rd;       // next data read address
    logic [PCW-1:0] r_fill, n_fill;   // bytes pushed into the current window
    logic           r_wrap, n_wrap;   // second pass from 0 in progress
    logic [DCW-1:0] r_start, n_start;
    logic [DCW-1:0] w_last;
    logic [ByteWidth-1:0] r_rdata;
    logic           r_rvld;

    logic           r_ovld, n_ovld;
    logic           r_found, n_found;
    logic           r_ofound, n_ofound;
    logic [OffsetWidth-1:0]  r_moff, n_moff;
    logic [TextPosWidth-1:0] r_tpos, n_tpos;
    logic [HlLenWidth-1:0]   r_hlen, n_hlen;

    logic w_acc;
    logic w_rd_en;
    t_cell_ctrl w_ctrl;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_last     = r_dcnt - DCW'(r_pcnt);

    // Memory writes for appends.
    always_ff @(posedge i_clk) begin
        if (w_acc && t_opcode'(i_in.opcode) == OP_APPEND_DATA
            && r_dcnt < DCW'(DATA_DEPTH)) begin
            r_dmem[r_dcnt[DAW-1:0]] <= i_in.byte_value;
        end
        if (w_acc && t_opcode'(i_in.opcode) == OP_APPEND_PATTERN
            && r_pcnt < PCW'(PATTERN_DEPTH)) begin
            r_pat[r_pcnt[PAW-1:0]] <= i_in.byte_value;
        end
    end

    // Registered data memory read.
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= r_dmem[r_rd[DAW-1:0]];
        end
    end

    // Cell row: cell k compares against pattern byte k; the newest byte
    // enters at cell pattern_count-1 and moves toward cell 0.
    logic [ByteWidth-1:0] w_cd  [PATTERN_DEPTH];
    logic [ByteWidth-1:0] w_cin [PATTERN_DEPTH];
    logic [PATTERN_DEPTH-1:0] w_eq;

    genvar g;
    generate
        for (g = 0; g < PATTERN_DEPTH; g++) begin : g_cell
            if (g == PATTERN_DEPTH - 1) begin : g_end
                assign w_cin[g] = r_rdata;
            end else begin : g_mid
                assign w_cin[g] = (PCW'(g + 1) == r_pcnt) ? r_rdata : w_cd[g+1];
            end
            wbps_cell u_cell (
                .i_clk  (i_clk),
                .i_ctrl (w_ctrl),
                .i_pat  (r_pat[g]),
                .i_data (w_cin[g]),
                .o_data (w_cd[g]),
                .o_eq   (w_eq[g])
            );
        end
    endgenerate

    // Match holds when every cell below pattern_count agrees.
    logic w_match;
    always_comb begin
        w_match = 1'b1;
        for (int k = 0; k < PATTERN_DEPTH; k++) begin
            if (PCW'(k) < r_pcnt && !w_eq[k]) begin
                w_match = 1'b0;
            end
        end
    end

    // Read-valid flag marks a byte arriving from memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= w_rd_en;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc && t_opcode'(i_in.opcode) == OP_SEARCH) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (r_dcnt == '0 || r_pcnt == '0 || CW'(r_pcnt) > CW'(r_dcnt)) begin
                    n_state = ST_RESULT;
                end else begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                // The last byte of the window shifts in at this edge.
                if (r_rvld && (r_fill + 1'b1) == r_pcnt) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (w_match) begin
                    n_state = ST_RESULT;
                end else if (r_pos == w_last) begin
                    if (!r_wrap && r_start != '0) begin
                        n_state = ST_FETCH;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end else begin
                    n_state = ST_FETCH;
                end
            end
            ST_RESULT: begin
                if (!r_ovld) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and output control.
    logic [DCW-1:0] w_ss;
    logic [3:0]     w_inl;
    logic [TextPosWidth-1:0] w_line77;
    logic [HlLenWidth-1:0]   w_room;
    always_comb begin
        n_dcnt   = r_dcnt;
        n_pcnt   = r_pcnt;
        n_pos    = r_pos;
        n_rd     = r_rd;
        n_fill   = r_fill;
        n_wrap   = r_wrap;
        n_start  = r_start;
        n_ovld   = r_ovld;
        n_found  = r_found;
        n_ofound = r_ofound;
        n_moff   = r_moff;
        n_tpos   = r_tpos;
        n_hlen   = r_hlen;
        w_rd_en  = 1'b0;
        w_ctrl   = '0;
        w_ss     = (SW'(i_in.start_offset) >= SW'(r_dcnt)) ? '0
                                                             : DCW'(i_in.start_offset);
        w_inl    = r_pos[3:0];
        w_line77 = TextPosWidth'((r_pos >> 4) * LineChars);
        w_room   = HlLenWidth'(LineBytes) - HlLenWidth'(w_inl);

        if (o_out.valid && o_out.ready) begin
            n_ovld = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    case (t_opcode'(i_in.opcode))
                        OP_APPEND_DATA: begin
                            if (r_dcnt < DCW'(DATA_DEPTH)) n_dcnt = r_dcnt + 1'b1;
                        end
                        OP_APPEND_PATTERN: begin
                            if (r_pcnt < PCW'(PATTERN_DEPTH)) n_pcnt = r_pcnt + 1'b1;
                        end
                        OP_CLEAR: begin
                            n_dcnt = '0;
                            n_pcnt = '0;
                        end
                        OP_SEARCH: begin
                            n_start = w_ss;
                            n_wrap  = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_START: begin
                n_found = 1'b0;
                n_fill  = '0;
                if (r_start > w_last) begin
                    n_wrap = 1'b1;
                    n_pos  = '0;
                    n_rd   = '0;
                end else begin
                    n_pos = r_start;
                    n_rd  = r_start;
                end
            end
            ST_FETCH: begin
                // Shift each arriving byte into the row.
                if (r_rvld) begin
                    w_ctrl.shift = 1'b1;
                    n_fill       = r_fill + 1'b1;
                end
                // Issue reads until the window is primed.
                w_rd_en = (r_rd < r_pos + DCW'(r_pcnt));
                if (w_rd_en) n_rd = r_rd + 1'b1;
            end
            ST_CHECK: begin
                if (w_match) begin
                    n_found = 1'b1;
                end else if (r_pos == w_last) begin
                    n_wrap = 1'b1;
                    n_pos  = '0;
                    n_rd   = '0;
                    n_fill = '0;
                end else begin
                    // Slide by one: one more byte primes the next window.
                    n_pos  = r_pos + 1'b1;
                    n_fill = r_pcnt - 1'b1;
                end
            end
            ST_RESULT: begin
                if (!r_ovld) begin
                    n_ovld   = 1'b1;
                    n_ofound = r_found;
                    n_moff   = r_found ? OffsetWidth'(r_pos) : '0;
                    n_tpos   = r_found ? TextPosWidth'(w_line77 + TextPosWidth'(TextColStart)
                                         + TextPosWidth'(w_inl)) : '0;
                    n_hlen   = !r_found ? '0 :
                               (HlLenWidth'(LW'(r_pcnt) > LW'(w_room) ? w_room
                                                                      : HlLenWidth'(r_pcnt)));
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dcnt  <= '0;
            r_pcnt  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dcnt  <= n_dcnt;
            r_pcnt  <= n_pcnt;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_rd     <= n_rd;
        r_fill   <= n_fill;
        r_wrap   <= n_wrap;
        r_start  <= n_start;
        r_found  <= n_found;
        r_ofound <= n_ofound;
        r_moff   <= n_moff;
        r_tpos   <= n_tpos;
        r_hlen   <= n_hlen;
    end

    assign o_out.valid            = r_ovld;
    assign o_out.found            = r_ofound;
    assign o_out.match_offset     = r_moff;
    assign o_out.text_position    = r_tpos;
    assign o_out.highlight_length = r_hlen;
endmodule
